// File: rtl/core/pwrp_pkg.sv
// Package for the peer wire receive parser: constants, codes and beat structs.
// Used by every file in rtl/core.
package pwrp_pkg;
  localparam int MAX_PIECES = 4096;
  localparam int BITMAP_WORDS = (MAX_PIECES + 63) / 64;
  localparam int WORD_BITS = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
  localparam int PIECE_BITS = $clog2(MAX_PIECES) + 1;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [3:0] EV_CHOKE = 4'd0;
  localparam logic [3:0] EV_UNCHOKE = 4'd1;
  localparam logic [3:0] EV_INTERESTED = 4'd2;
  localparam logic [3:0] EV_NOT_INTERESTED = 4'd3;
  localparam logic [3:0] EV_HAVE = 4'd4;
  localparam logic [3:0] EV_BITFIELD = 4'd5;
  localparam logic [3:0] EV_REQUEST = 4'd6;
  localparam logic [3:0] EV_PIECE = 4'd7;
  localparam logic [3:0] EV_CANCEL = 4'd8;
  localparam logic [3:0] EV_KEEPALIVE = 4'd9;
  localparam logic [3:0] EV_ABORT = 4'd10;
  localparam logic [3:0] EV_WORD_READ = 4'd11;
  localparam logic [3:0] EV_HANDSHAKE_OK = 4'd12;

  localparam logic [2:0] AR_PROTOCOL = 3'd0;
  localparam logic [2:0] AR_HASH = 3'd1;
  localparam logic [2:0] AR_SELF = 3'd2;
  localparam logic [2:0] AR_LENGTH = 3'd3;
  localparam logic [2:0] AR_ABORTED = 3'd4;

  localparam logic [2:0] REG_HASH_HI = 3'd0;
  localparam logic [2:0] REG_HASH_MID = 3'd1;
  localparam logic [2:0] REG_HASH_LO = 3'd2;
  localparam logic [2:0] REG_ID_HI = 3'd3;
  localparam logic [2:0] REG_ID_MID = 3'd4;
  localparam logic [2:0] REG_ID_LO = 3'd5;
  localparam logic [2:0] REG_PIECE_COUNT = 3'd6;
  localparam logic [2:0] REG_MAX_LEN = 3'd7;

  localparam logic [7:0] MT_CHOKE = 8'd0;
  localparam logic [7:0] MT_UNCHOKE = 8'd1;
  localparam logic [7:0] MT_INTERESTED = 8'd2;
  localparam logic [7:0] MT_NOT_INTERESTED = 8'd3;
  localparam logic [7:0] MT_HAVE = 8'd4;
  localparam logic [7:0] MT_BITFIELD = 8'd5;
  localparam logic [7:0] MT_REQUEST = 8'd6;
  localparam logic [7:0] MT_PIECE = 8'd7;
  localparam logic [7:0] MT_CANCEL = 8'd8;

  localparam logic [6:0] HS_DONE = 7'd68;

  typedef struct packed {
    logic [3:0]  event_res;
    logic [31:0] piece_number;
    logic [31:0] block_offset;
    logic [31:0] block_length;
    logic [7:0]  data_byte;
    logic        last_data;
    logic [2:0]  abort_reason;
    logic        choked_by_peer;
    logic        peer_interested;
    logic [63:0] bitmap_word;
  } result_t;

  // Classified work handed from the front to the bitmap back end.
  typedef struct packed {
    logic            has_result;  // a result beat follows
    logic            word_read;   // fill bitmap_word from the store
    logic [WORD_BITS-1:0] rd_word;
    logic            rd_in_range;
    logic            set_have;    // set one bit
    logic [31:0]     have_index;
    logic            set_bits;    // bitfield byte: set up to 8 bits
    logic [30:0]     bit_base;    // index of bit 0 of the byte (msb first)
    logic [7:0]      bits;
    result_t         res;
  } work_t;

  function automatic logic [7:0] proto_char(input logic [4:0] k);
    logic [7:0] c;
    case (k)
      5'd0: c = "B";  5'd1: c = "i";  5'd2: c = "t";  5'd3: c = "T";
      5'd4: c = "o";  5'd5: c = "r";  5'd6: c = "r";  5'd7: c = "e";
      5'd8: c = "n";  5'd9: c = "t";  5'd10: c = " "; 5'd11: c = "p";
      5'd12: c = "r"; 5'd13: c = "o"; 5'd14: c = "t"; 5'd15: c = "o";
      5'd16: c = "c"; 5'd17: c = "o"; 5'd18: c = "l";
      default: c = 8'd0;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] id_byte(input logic [63:0] hi, input logic [63:0] mid,
                                         input logic [31:0] lo, input logic [4:0] k);
    logic [7:0] r;
    if (k < 5'd8) r = hi[8*(7-k[2:0]) +: 8];
    else if (k < 5'd16) r = mid[8*(7-k[2:0]) +: 8];
    else r = lo[8*(3-k[1:0]) +: 8];
    return r;
  endfunction
endpackage

// File: rtl/core/pwrp_stream_if.sv
// Valid/ready channel interfaces for the parser's item and result beats.
// Depends on pwrp_pkg.
interface pwrp_item_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] rx_byte;
  logic [5:0] word_select;
  modport source(output valid, command, rx_byte, word_select, input ready);
  modport sink(input valid, command, rx_byte, word_select, output ready);
endinterface

interface pwrp_result_if;
  logic              valid;
  logic              ready;
  pwrp_pkg::result_t res;
  modport source(output valid, res, input ready);
  modport sink(input valid, res, output ready);
endinterface

// File: rtl/core/peer_wire_receive_parser_core.sv
// Top level of the peer wire receive parser: APB register file, front end,
// work queue and bitmap back end. Depends on pwrp_pkg, the stream interfaces
// and the pwrp_front, pwrp_queue and pwrp_back modules.
//
//   channel   direction  beat contents
//   items     in         command, rx_byte, word_select
//   results   out        result_t (event, fields, flags, bitmap word)
//   apb       in/out     eight configuration registers at 8*i
//
// One beat is accepted per cycle while the work queue has room; the front end
// keeps the parse state in registers and updates it in the accepting cycle.
// Each result passes from the accepted beat through the queue slot and the back
// end's registered bitmap read stage into the output register. The queue (two
// entries), the read stage and the output register let both sides stall apart.
// Reset (synchronous, active high) clears parse state, flags, queue and the
// per-word bitmap valid bits at once, so no clearing pass is needed.
module peer_wire_receive_parser_core (
  input  logic          clk,
  input  logic          rst,
  pwrp_item_if.sink     items,
  pwrp_result_if.source results,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [5:0]    paddr,
  input  logic [63:0]   pwdata,
  output logic [63:0]   prdata,
  output logic          pready
);
  logic [63:0] hash_hi, hash_mid, id_hi, id_mid;
  logic [31:0] hash_lo, id_lo;
  logic [12:0] piece_count;
  logic [30:0] max_len;
  logic [2:0]  reg_sel;
  logic        q_full, q_empty, q_pop, accept;
  pwrp_pkg::work_t front_work, q_data;

  assign pready = 1'b1;
  assign reg_sel = paddr[5:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_hi <= '0;
      hash_mid <= '0;
      hash_lo <= '0;
      id_hi <= '0;
      id_mid <= '0;
      id_lo <= '0;
      piece_count <= '0;
      max_len <= 31'd200000;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        pwrp_pkg::REG_HASH_HI: hash_hi <= pwdata;
        pwrp_pkg::REG_HASH_MID: hash_mid <= pwdata;
        pwrp_pkg::REG_HASH_LO: hash_lo <= pwdata[31:0];
        pwrp_pkg::REG_ID_HI: id_hi <= pwdata;
        pwrp_pkg::REG_ID_MID: id_mid <= pwdata;
        pwrp_pkg::REG_ID_LO: id_lo <= pwdata[31:0];
        pwrp_pkg::REG_PIECE_COUNT: piece_count <= pwdata[12:0];
        pwrp_pkg::REG_MAX_LEN: max_len <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      pwrp_pkg::REG_HASH_HI: prdata = hash_hi;
      pwrp_pkg::REG_HASH_MID: prdata = hash_mid;
      pwrp_pkg::REG_HASH_LO: prdata = {32'd0, hash_lo};
      pwrp_pkg::REG_ID_HI: prdata = id_hi;
      pwrp_pkg::REG_ID_MID: prdata = id_mid;
      pwrp_pkg::REG_ID_LO: prdata = {32'd0, id_lo};
      pwrp_pkg::REG_PIECE_COUNT: prdata = {51'd0, piece_count};
      pwrp_pkg::REG_MAX_LEN: prdata = {33'd0, max_len};
      default: prdata = '0;
    endcase
  end

  // Room is guaranteed when the back end drains in the same cycle.
  assign items.ready = !q_full || q_pop;
  assign accept = items.valid && items.ready;

  pwrp_front u_front (
    .clk, .rst,
    .in_valid(accept),
    .command(items.command),
    .rx_byte(items.rx_byte),
    .word_select(items.word_select),
    .hash_hi, .hash_mid, .hash_lo,
    .id_hi, .id_mid, .id_lo,
    .max_len,
    .work(front_work)
  );

  pwrp_queue u_queue (
    .clk, .rst,
    .push(accept),
    .push_data(front_work),
    .full(q_full),
    .pop(q_pop),
    .empty(q_empty),
    .pop_data(q_data)
  );

  pwrp_back u_back (
    .clk, .rst,
    .q_empty, .q_data, .q_pop,
    .piece_count,
    .out_valid(results.valid),
    .out_ready(results.ready),
    .out_res(results.res)
  );
endmodule

// File: rtl/core/pwrp_front.sv
// Front end: runs the handshake and message framing for each accepted beat and
// emits one classified work word per beat. Depends on pwrp_pkg.
module pwrp_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              command,
  input  logic [7:0]        rx_byte,
  input  logic [5:0]        word_select,
  input  logic [63:0]       hash_hi,
  input  logic [63:0]       hash_mid,
  input  logic [31:0]       hash_lo,
  input  logic [63:0]       id_hi,
  input  logic [63:0]       id_mid,
  input  logic [31:0]       id_lo,
  input  logic [30:0]       max_len,
  output pwrp_pkg::work_t   work
);
  logic [6:0]  hs_pos, hs_pos_next;
  logic [2:0]  len_seen, len_seen_next;
  logic [31:0] msg_len, msg_len_next;
  logic [30:0] msg_pos, msg_pos_next;
  logic [7:0]  msg_type, msg_type_next;
  logic [31:0] acc [3];
  logic [31:0] acc_next [3];
  logic        choked, choked_next, interested, interested_next, aborted, aborted_next;
  pwrp_pkg::work_t w;

  always_comb begin
    logic [4:0]  k;
    logic [31:0] nl;
    logic [30:0] q;
    logic        last;
    logic [7:0]  mt;
    hs_pos_next = hs_pos;
    len_seen_next = len_seen;
    msg_len_next = msg_len;
    msg_pos_next = msg_pos;
    msg_type_next = msg_type;
    acc_next = acc;
    choked_next = choked;
    interested_next = interested;
    aborted_next = aborted;
    k = 5'd0;
    nl = 32'd0;
    q = 31'd0;
    last = 1'b0;
    mt = msg_type;
    w = '0;
    w.rd_word = word_select[pwrp_pkg::WORD_BITS-1:0];
    w.rd_in_range = ({26'd0, word_select} < 32'(pwrp_pkg::BITMAP_WORDS));
    if (command) begin
      w.has_result = 1'b1;
      w.word_read = 1'b1;
      w.res.event_res = pwrp_pkg::EV_WORD_READ;
    end else if (aborted) begin
      w.has_result = 1'b1;
      w.res.event_res = pwrp_pkg::EV_ABORT;
      w.res.abort_reason = pwrp_pkg::AR_ABORTED;
    end else if (hs_pos < pwrp_pkg::HS_DONE) begin
      hs_pos_next = hs_pos + 7'd1;
      if (hs_pos == 7'd0) begin
        if (rx_byte != 8'd19) begin
          w.has_result = 1'b1;
          w.res.event_res = pwrp_pkg::EV_ABORT;
          w.res.abort_reason = pwrp_pkg::AR_PROTOCOL;
        end
      end else if (hs_pos <= 7'd19) begin
        k = 5'(hs_pos - 7'd1);
        if (rx_byte != pwrp_pkg::proto_char(k)) begin
          w.has_result = 1'b1;
          w.res.event_res = pwrp_pkg::EV_ABORT;
          w.res.abort_reason = pwrp_pkg::AR_PROTOCOL;
        end
      end else if (hs_pos <= 7'd27) begin
        k = 5'd0;
      end else if (hs_pos <= 7'd47) begin
        k = 5'(hs_pos - 7'd28);
        if (rx_byte != pwrp_pkg::id_byte(hash_hi, hash_mid, hash_lo, k)) begin
          w.has_result = 1'b1;
          w.res.event_res = pwrp_pkg::EV_ABORT;
          w.res.abort_reason = pwrp_pkg::AR_HASH;
        end
      end else begin
        k = 5'(hs_pos - 7'd48);
        if (k == 5'd0) acc_next[0] = 32'd1;
        if (rx_byte != pwrp_pkg::id_byte(id_hi, id_mid, id_lo, k)) acc_next[0] = 32'd0;
        if (k == 5'd19) begin
          w.has_result = 1'b1;
          if (acc_next[0][0]) begin
            w.res.event_res = pwrp_pkg::EV_ABORT;
            w.res.abort_reason = pwrp_pkg::AR_SELF;
          end else begin
            w.res.event_res = pwrp_pkg::EV_HANDSHAKE_OK;
          end
          acc_next[0] = 32'd0;
        end
      end
      if (w.res.event_res == pwrp_pkg::EV_ABORT && w.has_result) begin
        aborted_next = 1'b1;
        hs_pos_next = hs_pos;
      end
    end else if (len_seen < 3'd4) begin
      nl = {msg_len[23:0], rx_byte};
      msg_len_next = nl;
      len_seen_next = len_seen + 3'd1;
      if (len_seen == 3'd3) begin
        if (nl == 32'd0) begin
          w.has_result = 1'b1;
          w.res.event_res = pwrp_pkg::EV_KEEPALIVE;
          len_seen_next = 3'd0;
          msg_pos_next = 31'd0;
        end else if (nl > {1'b0, max_len}) begin
          w.has_result = 1'b1;
          w.res.event_res = pwrp_pkg::EV_ABORT;
          w.res.abort_reason = pwrp_pkg::AR_LENGTH;
          aborted_next = 1'b1;
        end else begin
          msg_pos_next = 31'd0;
        end
      end
    end else begin
      if (msg_pos == 31'd0) begin
        mt = rx_byte;
        msg_type_next = rx_byte;
        acc_next[0] = 32'd0;
        acc_next[1] = 32'd0;
        acc_next[2] = 32'd0;
      end else if (msg_pos <= 31'd12) begin
        q = msg_pos - 31'd1;
        acc_next[q[3:2]][8*(3-q[1:0]) +: 8] = rx_byte;
      end
      // Bitfield bytes past the store can never set a bit, so they are not sent on.
      if (mt == pwrp_pkg::MT_BITFIELD && msg_pos != 31'd0 &&
          msg_pos <= 31'(pwrp_pkg::MAX_PIECES / 8)) begin
        w.set_bits = 1'b1;
        w.bit_base = (msg_pos - 31'd1) << 3;
        w.bits = rx_byte;
      end
      last = ({1'b0, msg_pos} + 32'd1 == msg_len);
      w.res.piece_number = acc_next[0];
      msg_pos_next = msg_pos + 31'd1;
      if (last) begin
        len_seen_next = 3'd0;
        msg_len_next = 32'd0;
        msg_pos_next = 31'd0;
      end
      if (mt == pwrp_pkg::MT_PIECE && msg_pos >= 31'd9) begin
        w.has_result = 1'b1;
        w.res.event_res = pwrp_pkg::EV_PIECE;
        w.res.block_offset = acc_next[1];
        w.res.block_length = msg_len - 32'd9;
        w.res.data_byte = rx_byte;
        w.res.last_data = last;
      end else if (last) begin
        w.has_result = 1'b1;
        w.res.piece_number = 32'd0;
        unique case (mt)
          pwrp_pkg::MT_CHOKE: begin
            choked_next = 1'b1;
            w.res.event_res = pwrp_pkg::EV_CHOKE;
          end
          pwrp_pkg::MT_UNCHOKE: begin
            choked_next = 1'b0;
            w.res.event_res = pwrp_pkg::EV_UNCHOKE;
          end
          pwrp_pkg::MT_INTERESTED: begin
            interested_next = 1'b1;
            w.res.event_res = pwrp_pkg::EV_INTERESTED;
          end
          pwrp_pkg::MT_NOT_INTERESTED: begin
            interested_next = 1'b0;
            w.res.event_res = pwrp_pkg::EV_NOT_INTERESTED;
          end
          pwrp_pkg::MT_HAVE: begin
            w.res.event_res = pwrp_pkg::EV_HAVE;
            w.res.piece_number = acc_next[0];
            w.set_have = 1'b1;
            w.have_index = acc_next[0];
          end
          pwrp_pkg::MT_BITFIELD: w.res.event_res = pwrp_pkg::EV_BITFIELD;
          pwrp_pkg::MT_REQUEST, pwrp_pkg::MT_CANCEL: begin
            w.res.event_res = mt[3:0];
            w.res.piece_number = acc_next[0];
            w.res.block_offset = acc_next[1];
            w.res.block_length = acc_next[2];
          end
          pwrp_pkg::MT_PIECE: begin
            w.res.event_res = pwrp_pkg::EV_PIECE;
            w.res.piece_number = acc_next[0];
            w.res.block_offset = acc_next[1];
            w.res.last_data = 1'b1;
          end
          default: w.has_result = 1'b0;
        endcase
      end
    end
    w.res.choked_by_peer = choked_next;
    w.res.peer_interested = interested_next;
  end

  assign work = w;

  always_ff @(posedge clk) begin
    if (rst) begin
      hs_pos <= '0;
      len_seen <= '0;
      msg_len <= '0;
      msg_pos <= '0;
      msg_type <= '0;
      acc[0] <= '0;
      acc[1] <= '0;
      acc[2] <= '0;
      choked <= 1'b1;
      interested <= 1'b0;
      aborted <= 1'b0;
    end else if (in_valid) begin
      hs_pos <= hs_pos_next;
      len_seen <= len_seen_next;
      msg_len <= msg_len_next;
      msg_pos <= msg_pos_next;
      msg_type <= msg_type_next;
      acc <= acc_next;
      choked <= choked_next;
      interested <= interested_next;
      aborted <= aborted_next;
    end
  end
endmodule

// File: rtl/core/pwrp_queue.sv
// Short work queue between the front end and the bitmap back end.
// Depends on pwrp_pkg.
module pwrp_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  pwrp_pkg::work_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output pwrp_pkg::work_t pop_data
);
  localparam int PB = $clog2(pwrp_pkg::QUEUE_DEPTH);
  pwrp_pkg::work_t slots [pwrp_pkg::QUEUE_DEPTH];
  logic [PB-1:0] wr_ptr, rd_ptr;
  logic [PB:0]   count;

  assign full = (count == (PB+1)'(pwrp_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (PB+1)'(push) - (PB+1)'(pop);
    end
  end
endmodule

// File: rtl/core/pwrp_back.sv
// Back end: a registered bitmap read stage, then the result register. Bitmap
// updates are read-modify-write with a bypass; per-word valid bits are cleared
// at reset. Depends on pwrp_pkg.
module pwrp_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  pwrp_pkg::work_t   q_data,
  output logic              q_pop,
  input  logic [12:0]       piece_count,
  output logic              out_valid,
  input  logic              out_ready,
  output pwrp_pkg::result_t out_res
);
  localparam int W = pwrp_pkg::WORD_BITS;
  logic [63:0] bitmap [pwrp_pkg::BITMAP_WORDS];
  logic [pwrp_pkg::BITMAP_WORDS-1:0] word_ok;
  logic [31:0] limit;
  logic        can_take;
  logic        s1_fire;
  logic        wr_en;
  logic [W-1:0] wr_addr;
  logic [W-1:0] rd_addr;
  logic [63:0] wr_mask;
  // Read stage: holds one work word while its bitmap word is read.
  logic        s1_valid;
  pwrp_pkg::result_t s1_res;
  logic        s1_has_result;
  logic        s1_word_read;
  logic        s1_in_range;
  logic        s1_wr_en;
  logic [W-1:0] s1_addr;
  logic [63:0] s1_mask;
  logic [63:0] rd_q;
  logic        rd_ok;
  logic        byp_hit;
  logic [63:0] byp_data;
  logic [63:0] cur_word;
  logic [63:0] merged;
  pwrp_pkg::result_t res_next;

  assign limit = ({19'd0, piece_count} < 32'(pwrp_pkg::MAX_PIECES)) ?
                 {19'd0, piece_count} : 32'(pwrp_pkg::MAX_PIECES);
  assign can_take = !out_valid || out_ready;
  assign s1_fire = s1_valid && can_take;
  assign q_pop = !q_empty && (!s1_valid || can_take);
  assign rd_addr = q_data.word_read ? q_data.rd_word : wr_addr;

  // A write retiring in the same cycle as the read of that word is forwarded.
  assign cur_word = byp_hit ? byp_data : (rd_ok ? rd_q : 64'd0);
  assign merged = cur_word | s1_mask;

  always_comb begin
    res_next = s1_res;
    res_next.bitmap_word = (s1_word_read && s1_in_range) ? cur_word : 64'd0;
  end

  always_comb begin
    logic [31:0] idx;
    wr_en = 1'b0;
    wr_addr = '0;
    wr_mask = '0;
    idx = '0;
    if (q_data.set_have) begin
      idx = q_data.have_index;
      if (idx < limit) begin
        wr_en = 1'b1;
        wr_addr = idx[W+5:6];
        wr_mask[idx[5:0]] = 1'b1;
      end
    end else if (q_data.set_bits) begin
      // A bitfield byte covers eight bits of one word, msb first.
      wr_addr = q_data.bit_base[W+5:6];
      for (int b = 0; b < 8; b++) begin
        idx = {1'b0, q_data.bit_base} + 32'(b);
        if (q_data.bits[7-b] && idx < limit) begin
          wr_en = 1'b1;
          wr_mask[idx[5:0]] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rd_q <= bitmap[rd_addr];
      byp_data <= merged;
      s1_res <= q_data.res;
      s1_has_result <= q_data.has_result;
      s1_word_read <= q_data.word_read;
      s1_in_range <= q_data.rd_in_range;
      s1_wr_en <= wr_en;
      s1_addr <= rd_addr;
      s1_mask <= wr_mask;
    end
    if (s1_fire && s1_wr_en) bitmap[s1_addr] <= merged;
    if (s1_fire) out_res <= res_next;
    if (rst) begin
      word_ok <= '0;
      rd_ok <= 1'b0;
      byp_hit <= 1'b0;
      s1_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_fire && s1_wr_en) word_ok[s1_addr] <= 1'b1;
      if (q_pop) begin
        rd_ok <= word_ok[rd_addr];
        byp_hit <= s1_fire && s1_wr_en && (s1_addr == rd_addr);
      end
      if (q_pop) s1_valid <= 1'b1;
      else if (s1_fire) s1_valid <= 1'b0;
      if (s1_fire) out_valid <= s1_has_result;
      else if (out_ready) out_valid <= 1'b0;
    end
  end
endmodule

// File: dv/peer_wire_receive_parser_core_tb.sv
// Self-checking testbench for peer_wire_receive_parser_core: drives handshake and message
// byte streams plus bitmap word reads, and predicts every result beat in a scoreboard class.
// Depends on pwrp_pkg, the stream interfaces and the parser RTL.
`timescale 1ns / 100ps

module peer_wire_receive_parser_core_tb;
  import pwrp_pkg::*;

  // Scoreboard: a bit-level copy of the parser's behavior plus the queue of beats that
  // the parser still owes us. note_item() advances the copy for every accepted input
  // beat; check() compares each output beat with the oldest owed one.
  class parse_scoreboard;
    logic [63:0] hash_hi, hash_mid, id_hi, id_mid;
    logic [31:0] hash_lo, id_lo;
    logic [12:0] piece_cfg;
    logic [30:0] len_cap;
    int unsigned hs_pos, len_seen, msg_pos;
    logic [31:0] msg_len;
    logic [7:0]  msg_type;
    logic [31:0] acc [3];
    bit          choked, interested, aborted;
    logic [63:0] have_map [64];
    result_t     awaited [$];
    int          errors, n_items, n_results;
    int          ev_seen [16];

    function new();
      hash_hi = '0; hash_mid = '0; hash_lo = '0;
      id_hi = '0; id_mid = '0; id_lo = '0;
      piece_cfg = '0; len_cap = 31'd200000;
      hs_pos = 0; len_seen = 0; msg_pos = 0; msg_len = '0; msg_type = '0;
      acc = '{default: '0};
      choked = 1; interested = 0; aborted = 0;
      have_map = '{default: '0};
      errors = 0; n_items = 0; n_results = 0;
      ev_seen = '{default: 0};
    endfunction

    function void set_reg(logic [2:0] idx, logic [63:0] v);
      case (idx)
        REG_HASH_HI:     hash_hi = v;
        REG_HASH_MID:    hash_mid = v;
        REG_HASH_LO:     hash_lo = v[31:0];
        REG_ID_HI:       id_hi = v;
        REG_ID_MID:      id_mid = v;
        REG_ID_LO:       id_lo = v[31:0];
        REG_PIECE_COUNT: piece_cfg = v[12:0];
        REG_MAX_LEN:     len_cap = v[30:0];
        default: ;
      endcase
    endfunction

    // Indexes at or above either the configured count or the store size are dropped.
    function void mark_piece(logic [63:0] idx);
      logic [63:0] lim;
      lim = (piece_cfg < MAX_PIECES) ? 64'(piece_cfg) : 64'(MAX_PIECES);
      if (idx < lim) have_map[idx >> 6][idx[5:0]] = 1'b1;
    endfunction

    function bit seal(inout result_t r, input logic [3:0] ev);
      r.event_res = ev;
      r.choked_by_peer = choked;
      r.peer_interested = interested;
      return 1'b1;
    endfunction

    function bit abort_with(inout result_t r, input logic [2:0] why);
      aborted = 1;
      r.abort_reason = why;
      return seal(r, EV_ABORT);
    endfunction

    function void end_msg();
      len_seen = 0; msg_len = '0; msg_pos = 0;
    endfunction

    function bit parse_step(bit cmd, logic [7:0] b, logic [5:0] ws, output result_t r);
      string       proto;
      logic [159:0] ref_bytes;
      int unsigned p, q, k;
      bit          same, last;
      proto = "BitTorrent protocol";
      r = '0;
      if (cmd) begin
        r.bitmap_word = have_map[ws];
        return seal(r, EV_WORD_READ);
      end
      if (aborted) return abort_with(r, AR_ABORTED);

      if (hs_pos < 68) begin
        p = hs_pos;
        if (p == 0) begin
          if (b != 8'd19) return abort_with(r, AR_PROTOCOL);
        end else if (p <= 19) begin
          if (b != proto[p-1]) return abort_with(r, AR_PROTOCOL);
        end else if (p <= 27) begin
          // Reserved bytes carry nothing we check.
        end else if (p <= 47) begin
          ref_bytes = {hash_hi, hash_mid, hash_lo};
          if (b != ref_bytes[159 - 8*(p-28) -: 8]) return abort_with(r, AR_HASH);
        end else begin
          k = p - 48;
          ref_bytes = {id_hi, id_mid, id_lo};
          if (k == 0) acc[0] = 32'd1;
          if (b != ref_bytes[159 - 8*k -: 8]) acc[0] = '0;
          if (k == 19) begin
            same = acc[0][0];
            acc[0] = '0;
            if (same) return abort_with(r, AR_SELF);
            hs_pos = 68;
            return seal(r, EV_HANDSHAKE_OK);
          end
        end
        hs_pos = p + 1;
        return 1'b0;
      end

      if (len_seen < 4) begin
        msg_len = {msg_len[23:0], b};
        len_seen++;
        if (len_seen == 4) begin
          if (msg_len == 0) begin
            end_msg();
            return seal(r, EV_KEEPALIVE);
          end
          if (msg_len > {1'b0, len_cap}) return abort_with(r, AR_LENGTH);
          msg_pos = 0;
        end
        return 1'b0;
      end

      p = msg_pos;
      if (p == 0) begin
        msg_type = b;
        acc = '{default: '0};
      end else if (p <= 12) begin
        q = p - 1;
        acc[q/4] |= {24'd0, b} << (8*(3 - q%4));
      end
      if (msg_type == MT_BITFIELD && p >= 1)
        for (int j = 0; j < 8; j++)
          if (b[7-j]) mark_piece(64'(p-1)*8 + 64'(j));
      last = (32'(p + 1) == msg_len);

      r.piece_number = acc[0];
      if (msg_type == MT_PIECE && p >= 9) begin
        r.block_offset = acc[1];
        r.block_length = msg_len - 32'd9;
        r.data_byte = b;
        r.last_data = last;
        if (last) end_msg();
        else msg_pos = p + 1;
        return seal(r, EV_PIECE);
      end
      if (!last) begin
        msg_pos = p + 1;
        return 1'b0;
      end
      end_msg();
      case (msg_type)
        MT_CHOKE:          begin r.piece_number = '0; choked = 1; return seal(r, EV_CHOKE); end
        MT_UNCHOKE:        begin r.piece_number = '0; choked = 0; return seal(r, EV_UNCHOKE); end
        MT_INTERESTED:     begin
          r.piece_number = '0; interested = 1; return seal(r, EV_INTERESTED);
        end
        MT_NOT_INTERESTED: begin
          r.piece_number = '0; interested = 0; return seal(r, EV_NOT_INTERESTED);
        end
        MT_HAVE:           begin mark_piece(64'(acc[0])); return seal(r, EV_HAVE); end
        MT_BITFIELD:       begin r.piece_number = '0; return seal(r, EV_BITFIELD); end
        MT_REQUEST, MT_CANCEL: begin
          r.block_offset = acc[1];
          r.block_length = acc[2];
          return seal(r, msg_type[3:0]);
        end
        MT_PIECE:          begin
          // Piece too short to carry any payload.
          r.block_offset = acc[1];
          r.last_data = 1'b1;
          return seal(r, EV_PIECE);
        end
        default: return 1'b0;
      endcase
    endfunction

    function void note_item(bit cmd, logic [7:0] b, logic [5:0] ws);
      result_t r;
      n_items++;
      if (parse_step(cmd, b, ws, r)) awaited.push_back(r);
    endfunction

    function void cmp(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check(result_t got);
      result_t e;
      if (awaited.size() == 0) begin
        $error("unexpected result beat, event %0d", got.event_res);
        errors++;
        return;
      end
      e = awaited.pop_front();
      n_results++;
      ev_seen[e.event_res]++;
      cmp("event_res", e.event_res, got.event_res);
      cmp("piece_number", e.piece_number, got.piece_number);
      cmp("block_offset", e.block_offset, got.block_offset);
      cmp("block_length", e.block_length, got.block_length);
      cmp("data_byte", e.data_byte, got.data_byte);
      cmp("last_data", e.last_data, got.last_data);
      cmp("abort_reason", e.abort_reason, got.abort_reason);
      cmp("choked_by_peer", e.choked_by_peer, got.choked_by_peer);
      cmp("peer_interested", e.peer_interested, got.peer_interested);
      cmp("bitmap_word", e.bitmap_word, got.bitmap_word);
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [5:0]  paddr;
  logic [63:0] pwdata, prdata;
  logic        pready;

  pwrp_item_if   items_if();
  pwrp_result_if res_if();

  parse_scoreboard sb;
  bit gaps_on;   // random idle bursts on both channels
  bit hold_req;  // asks the result side for one long hold-off
  int idle_cycles;

  peer_wire_receive_parser_core i_dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_if),
    .results (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  // Result sampling and the watchdog share the rising edge. The watchdog only counts
  // cycles in which no beat and no register access happened.
  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready) sb.check(res_if.res);
    if ((items_if.valid && items_if.ready) || (res_if.valid && res_if.ready) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= 5000) begin
      $display("watchdog: nothing moved for %0d cycles", idle_cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Result side ready. Each pass through the loop makes exactly one assignment at a
  // falling edge, so ready never gets two updates in one time step.
  initial begin
    res_if.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        // Long hold-off: the sender keeps going, so the queue fills and input stalls.
        res_if.ready <= 1'b0;
        repeat (80) @(negedge clk);
        hold_req = 1'b0;
      end else if (gaps_on && $urandom_range(0, 6) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk);
      end else begin
        res_if.ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // Every task below is entered and left at a falling edge.
  task automatic send_item(bit cmd, logic [7:0] b, logic [5:0] ws);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      items_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    items_if.valid <= 1'b1;
    items_if.command <= cmd;
    items_if.rx_byte <= b;
    items_if.word_select <= ws;
    do @(posedge clk); while (!items_if.ready);
    sb.note_item(cmd, b, ws);
    @(negedge clk);
  endtask

  // A stream byte, now and then preceded by a bitmap word read.
  task automatic put_byte(logic [7:0] b);
    if ($urandom_range(0, 9) == 0) send_item(1'b1, 8'($urandom), 6'($urandom));
    send_item(1'b0, b, 6'($urandom));
  endtask

  task automatic put_len(logic [31:0] len);
    for (int i = 3; i >= 0; i--) put_byte(len[8*i +: 8]);
  endtask

  function automatic void push_word(ref logic [7:0] q [$], input logic [31:0] v);
    for (int i = 3; i >= 0; i--) q.push_back(v[8*i +: 8]);
  endfunction

  task automatic frame(logic [7:0] mtype, logic [7:0] body [$]);
    put_len(32'(body.size() + 1));
    put_byte(mtype);
    foreach (body[i]) put_byte(body[i]);
  endtask

  task automatic reg_write(logic [2:0] idx, logic [63:0] v);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 3'b000}; pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, v);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0;
  endtask

  // Waits until every owed beat has arrived, then keeps idling, because a byte
  // that yields no result may still sit in the queue behind the last one.
  task automatic drain();
    items_if.valid <= 1'b0;
    while (sb.awaited.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // The handshake: protocol header, reserved bytes, our hash, then a peer id that
  // differs from ours in one byte (the one named by diff_at).
  task automatic handshake(int diff_at);
    string proto;
    logic [159:0] hash_v, id_v;
    logic [7:0]   b;
    proto = "BitTorrent protocol";
    hash_v = {sb.hash_hi, sb.hash_mid, sb.hash_lo};
    id_v = {sb.id_hi, sb.id_mid, sb.id_lo};
    put_byte(8'd19);
    for (int i = 0; i < 19; i++) put_byte(proto[i]);
    for (int i = 0; i < 8; i++) put_byte(8'($urandom));
    for (int i = 0; i < 20; i++) put_byte(hash_v[159 - 8*i -: 8]);
    for (int i = 0; i < 20; i++) begin
      b = id_v[159 - 8*i -: 8];
      if (i == diff_at) b ^= 8'($urandom_range(1, 255));
      put_byte(b);
    end
  endtask

  function automatic logic [31:0] pick_index();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return $urandom_range(0, int'(sb.piece_cfg) + 8);
  endfunction

  // One well-formed message with random content; a share of them are cut short,
  // padded, of unknown type, or plain keepalives.
  task automatic random_msg();
    logic [7:0] body [$];
    logic [7:0] mtype;
    int kind, n;
    kind = $urandom_range(0, 19);
    if (kind == 0) begin
      put_len(32'd0);
      return;
    end
    mtype = (kind == 19) ? 8'($urandom_range(9, 255)) : 8'($urandom_range(0, 8));
    case (mtype)
      MT_HAVE: push_word(body, pick_index());
      MT_BITFIELD: begin
        n = $urandom_range(1, 10);
        repeat (n) body.push_back(8'($urandom));
      end
      MT_REQUEST, MT_CANCEL: begin
        push_word(body, pick_index());
        push_word(body, $urandom);
        push_word(body, $urandom);
      end
      MT_PIECE: begin
        push_word(body, pick_index());
        push_word(body, $urandom);
        n = $urandom_range(0, 6);
        repeat (n) body.push_back(8'($urandom));
      end
      MT_CHOKE, MT_UNCHOKE, MT_INTERESTED, MT_NOT_INTERESTED: ;
      default: begin
        n = $urandom_range(0, 3);
        repeat (n) body.push_back(8'($urandom));
      end
    endcase
    case ($urandom_range(0, 9))
      0: begin
        n = $urandom_range(0, body.size());
        while (body.size() > n) void'(body.pop_back());
      end
      1: repeat ($urandom_range(1, 3)) body.push_back(8'($urandom));
      default: ;
    endcase
    while (body.size() + 1 > sb.len_cap) void'(body.pop_back());
    frame(mtype, body);
  endtask

  task automatic random_phase(int count);
    int start;
    start = sb.n_items;
    while (sb.n_items - start < count) random_msg();
  endtask

  initial begin
    logic [7:0] body [$];
    sb = new();
    gaps_on = 1'b1;
    hold_req = 1'b0;
    idle_cycles = 0;
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    items_if.valid = 1'b0;
    items_if.command = 1'b0;
    items_if.rx_byte = '0;
    items_if.word_select = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Every register once, with the store size as piece count and the widest length limit.
    reg_write(REG_HASH_HI, {$urandom, $urandom});
    reg_write(REG_HASH_MID, {$urandom, $urandom});
    reg_write(REG_HASH_LO, 64'($urandom));
    reg_write(REG_ID_HI, {$urandom, $urandom});
    reg_write(REG_ID_MID, {$urandom, $urandom});
    reg_write(REG_ID_LO, 64'($urandom));
    reg_write(REG_PIECE_COUNT, 64'd4096);
    reg_write(REG_MAX_LEN, 64'h7fff_ffff);

    // Directed part: a peer id that differs only in its last byte, then one of each
    // message, the store boundary for have, and the short, long, empty and unknown cases.
    handshake(19);
    put_len(32'd0);
    frame(MT_CHOKE, body);
    frame(MT_UNCHOKE, body);
    frame(MT_INTERESTED, body);
    frame(MT_NOT_INTERESTED, body);
    body = {}; push_word(body, 32'd4095); frame(MT_HAVE, body);
    body = {}; push_word(body, 32'd4096); frame(MT_HAVE, body);
    body = {}; push_word(body, 32'hffff_ffff); frame(MT_HAVE, body);
    body = {8'hff, 8'h80}; frame(MT_BITFIELD, body);
    body = {}; push_word(body, 32'd7); push_word(body, 32'h4000); push_word(body, 32'h4000);
    frame(MT_REQUEST, body);
    body = {}; push_word(body, 32'd3); push_word(body, 32'hffff_ffff);
    body.push_back(8'h00); body.push_back(8'hff); body.push_back(8'h5a);
    frame(MT_PIECE, body);
    body = {}; push_word(body, 32'd9); push_word(body, 32'h10); push_word(body, 32'h20);
    frame(MT_CANCEL, body);
    body = {8'h12, 8'h34}; frame(8'd200, body);
    body = {8'h00, 8'h01}; frame(MT_HAVE, body);
    body = {}; push_word(body, 32'd5); frame(MT_PIECE, body);
    body = {}; push_word(body, 32'd1); push_word(body, 32'd2); push_word(body, 32'd3);
    body.push_back(8'haa); body.push_back(8'h55);
    frame(MT_REQUEST, body);
    send_item(1'b1, 8'h00, 6'd0);
    send_item(1'b1, 8'hff, 6'd63);
    drain();

    // No pieces counted, and a short length limit.
    reg_write(REG_PIECE_COUNT, 64'd0);
    reg_write(REG_MAX_LEN, 64'd13);
    random_phase(330);
    drain();

    // A count above the store size. Midway the result side holds off for a long
    // stretch, and later the sender waits for every owed beat before going on.
    reg_write(REG_PIECE_COUNT, 64'd8191);
    reg_write(REG_MAX_LEN, 64'd200000);
    random_phase(150);
    hold_req = 1'b1;
    random_phase(100);
    items_if.valid <= 1'b0;
    while (sb.awaited.size() != 0) @(negedge clk);
    random_phase(80);
    drain();

    reg_write(REG_PIECE_COUNT, 64'($urandom_range(1, 4095)));
    reg_write(REG_MAX_LEN, 64'($urandom_range(13, 100000)));
    random_phase(330);
    drain();

    // From here on the bench runs without idle bursts on either side.
    gaps_on = 1'b0;
    reg_write(REG_PIECE_COUNT, 64'd1);
    random_phase(330);
    drain();

    // Length limit of one: a length with the top bit set aborts, and every byte
    // after that reports the sticky abort while word reads still answer.
    reg_write(REG_MAX_LEN, 64'd1);
    put_len(32'h8000_0005);
    repeat (30) send_item(1'($urandom), 8'($urandom), 6'($urandom));
    drain();

    $display("Covered %0d input beats and %0d result beats: %0d byte events, %0d aborts,",
             sb.n_items, sb.n_results, sb.ev_seen[EV_PIECE], sb.ev_seen[EV_ABORT]);
    $display("%0d word reads, %0d have and %0d bitfield messages across six settings.",
             sb.ev_seen[EV_WORD_READ], sb.ev_seen[EV_HAVE], sb.ev_seen[EV_BITFIELD]);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
